// ===== hdl/hffa_pkg.sv =====
`default_nettype none
package hffa_pkg;

	localparam int unsigned SUM_W = 34;
	localparam int unsigned DVD_W = 54;
	localparam int unsigned DVS_W = 44;
	localparam int unsigned CNT_W = 6;

	localparam logic [23:0] BACKGROUND_ID = 24'hFFFFFF;
	localparam logic [30:0] INV_PI_Q32 = 31'd1367130551;
	localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

	localparam logic [CNT_W-1:0] WGT_STEPS = CNT_W'(DVD_W);

	typedef struct packed {
		logic capture;
		logic calc_row;
		logic div_ld_wgt;
		logic div_step;
		logic calc_uv;
		logic calc_sq;
		logic calc_d;
		logic calc_kd2;
		logic calc_prod;
		logic mem_rd;
		logic mem_wr_acc;
		logic mem_wr_rd;
		logic res_zero;
		logic out_load;
		logic clr_we;
	} hffa_cmd_t;

	typedef struct packed {
		logic kind;
		logic skip;
		logic in_range;
	} hffa_sts_t;

endpackage
`default_nettype wire

// ===== hdl/hffa_datapath.sv =====
`default_nettype none
module hffa_datapath #(
	parameter int unsigned RES = 128,
	parameter int unsigned MAX_PATCHES = 1024,
	parameter int unsigned AW = $clog2(MAX_PATCHES)
) (
	input  wire logic                  clk,
	input  wire hffa_pkg::hffa_cmd_t   cmd,
	input  wire logic [AW-1:0]         clr_addr,
	input  wire logic                  kind,
	input  wire logic [2:0]            face,
	input  wire logic [13:0]           pixel_index,
	input  wire logic [23:0]           visible_id,
	output hffa_pkg::hffa_sts_t        sts,
	output logic [33:0]                ff_accum,
	output logic                       present
);
	import hffa_pkg::*;

	localparam logic [20:0] PIX = 21'(RES * RES);
	localparam logic [20:0] HALF = 21'((RES * RES) / 2);
	localparam logic [21:0] RSQ = 22'(RES * RES);
	localparam logic [22:0] KTOP = 23'(4 * RES * RES);
	localparam logic [22:0] KR = 23'(4 * RES);
	localparam logic [24:0] MAXP = 25'(MAX_PATCHES);
	// row = floor(idx / RES) by reciprocal multiply, exact for any 14-bit index
	localparam int unsigned RSH = 14 + $clog2(RES);
	localparam logic [15:0] RECIP = 16'(((1 << RSH) + RES - 1) / RES);
	localparam logic [13:0] RES_W = 14'(RES);

	logic              kind_q;
	logic [2:0]        face_q;
	logic [13:0]       idx_q;
	logic [23:0]       id_q;
	logic [9:0]        row_q;
	logic [DVD_W-1:0]  dvd_q;
	logic [DVS_W:0]    rem_q;
	logic [DVS_W-1:0]  dvs_q;
	logic signed [11:0] u_q, v_q;
	logic [19:0]       usq_q, vsq_q;
	logic [21:0]       d_q;
	logic [DVS_W-1:0]  d2_q;
	logic [22:0]       k_q;
	logic [DVD_W-1:0]  prod_q;
	logic [34:0]       mem [MAX_PATCHES];
	logic [34:0]       rdata_q;
	logic [34:0]       res_q;

	logic [DVS_W:0]    rem_sh;
	logic              ge;
	logic [29:0]       rowp_n;
	logic [13:0]       col_n;
	logic signed [11:0] u_n, v_n;
	logic signed [23:0] usq_n, vsq_n;
	logic [45:0]       kv_n;
	logic [54:0]       acc_n;
	logic [SUM_W-1:0]  sat_n;
	logic [AW-1:0]     addr;

	assign addr = id_q[AW-1:0];
	assign sts.kind = kind_q;
	assign sts.in_range = {1'b0, id_q} < MAXP;
	assign sts.skip = (id_q == BACKGROUND_ID) || !sts.in_range || (face_q > 3'd4)
		|| ({7'b0, idx_q} >= PIX) || ((face_q != 3'd0) && ({7'b0, idx_q} < HALF));

	assign rem_sh = {rem_q[DVS_W-1:0], dvd_q[DVD_W-1]};
	assign ge = rem_sh >= {1'b0, dvs_q};

	assign rowp_n = {16'b0, idx_q} * {14'b0, RECIP};
	assign col_n = idx_q - ({4'b0, row_q} * RES_W);
	assign u_n = $signed({1'b0, col_n[9:0], 1'b1}) - $signed(12'(RES));
	assign v_n = $signed({1'b0, row_q, 1'b1}) - $signed(12'(RES));
	assign usq_n = u_q * u_q;
	assign vsq_n = v_q * v_q;
	assign kv_n = KR * {12'b0, v_q[10:0]};

	assign acc_n = {21'b0, rdata_q[SUM_W-1:0]} + {1'b0, dvd_q};
	assign sat_n = (acc_n > {21'b0, SUM_MAX}) ? SUM_MAX : acc_n[SUM_W-1:0];

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q <= kind;
			face_q <= face;
			idx_q <= pixel_index;
			id_q <= visible_id;
		end
		if (cmd.calc_row) begin
			row_q <= 10'(rowp_n >> RSH);
		end
		if (cmd.div_ld_wgt) begin
			dvd_q <= prod_q;
			dvs_q <= d2_q;
			rem_q <= '0;
		end else if (cmd.div_step) begin
			if (ge) begin
				rem_q <= rem_sh - {1'b0, dvs_q};
				dvd_q <= {dvd_q[DVD_W-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				dvd_q <= {dvd_q[DVD_W-2:0], 1'b0};
			end
		end
		if (cmd.calc_uv) begin
			u_q <= u_n;
			v_q <= v_n;
		end
		if (cmd.calc_sq) begin
			usq_q <= usq_n[19:0];
			vsq_q <= vsq_n[19:0];
		end
		if (cmd.calc_d) begin
			d_q <= {2'b0, usq_q} + {2'b0, vsq_q} + RSQ;
		end
		if (cmd.calc_kd2) begin
			d2_q <= d_q * d_q;
			if (face_q == 3'd0) begin
				k_q <= KTOP;
			end else if (v_q[11]) begin
				k_q <= '0;
			end else begin
				k_q <= kv_n[22:0];
			end
		end
		if (cmd.calc_prod) begin
			prod_q <= k_q * INV_PI_Q32;
		end
		if (cmd.mem_rd) begin
			rdata_q <= mem[addr];
		end
		if (cmd.clr_we) begin
			mem[clr_addr] <= '0;
		end else if (cmd.mem_wr_acc) begin
			mem[addr] <= {1'b1, sat_n};
		end else if (cmd.mem_wr_rd) begin
			mem[addr] <= '0;
		end
		if (cmd.res_zero) begin
			res_q <= '0;
		end else if (cmd.mem_wr_rd) begin
			res_q <= rdata_q;
		end
		if (cmd.out_load) begin
			ff_accum <= res_q[SUM_W-1:0];
			present <= res_q[SUM_W];
		end
	end
endmodule
`default_nettype wire

// ===== hdl/hffa_ctrl.sv =====
`default_nettype none
module hffa_ctrl #(
	parameter int unsigned MAX_PATCHES = 1024,
	parameter int unsigned AW = $clog2(MAX_PATCHES)
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	input  wire hffa_pkg::hffa_sts_t  sts,
	output hffa_pkg::hffa_cmd_t       cmd,
	output logic [AW-1:0]             clr_addr
);
	import hffa_pkg::*;

	typedef enum logic [3:0] {
		S_CLR, S_IDLE, S_CHK, S_ROW, S_UV, S_SQ, S_D, S_KD2, S_PROD, S_DIV,
		S_RD, S_WR, S_OUT
	} state_t;

	state_t           state_q;
	logic [AW:0]      clr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             accept;

	assign in_stall = (state_q != S_IDLE);
	assign accept = in_valid && !in_stall;
	assign clr_addr = clr_q[AW-1:0];

	always_comb begin
		cmd = '0;
		cmd.clr_we = (state_q == S_CLR);
		cmd.capture = accept;
		cmd.calc_row = (state_q == S_ROW);
		cmd.res_zero = (state_q == S_CHK) && sts.kind && !sts.in_range;
		cmd.calc_uv = (state_q == S_UV);
		cmd.calc_sq = (state_q == S_SQ);
		cmd.calc_d = (state_q == S_D);
		cmd.calc_kd2 = (state_q == S_KD2);
		cmd.calc_prod = (state_q == S_PROD);
		cmd.div_ld_wgt = (state_q == S_DIV) && (cnt_q == WGT_STEPS);
		cmd.div_step = (state_q == S_DIV) && (cnt_q != WGT_STEPS);
		cmd.mem_rd = (state_q == S_RD);
		cmd.mem_wr_acc = (state_q == S_WR) && !sts.kind;
		cmd.mem_wr_rd = (state_q == S_WR) && sts.kind;
		cmd.out_load = (state_q == S_OUT) && (!out_valid || !out_stall);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			clr_q <= '0;
			cnt_q <= '0;
			out_valid <= 1'b0;
		end else begin
			if (cmd.out_load) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == (AW+1)'(MAX_PATCHES - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						state_q <= S_CHK;
					end
				end
				S_CHK: begin
					if (sts.kind) begin
						state_q <= sts.in_range ? S_RD : S_OUT;
					end else if (sts.skip) begin
						state_q <= S_IDLE;
					end else begin
						state_q <= S_ROW;
					end
				end
				S_ROW:  state_q <= S_UV;
				S_UV:   state_q <= S_SQ;
				S_SQ:   state_q <= S_D;
				S_D:    state_q <= S_KD2;
				S_KD2:  state_q <= S_PROD;
				S_PROD: begin
					cnt_q <= WGT_STEPS;
					state_q <= S_DIV;
				end
				S_DIV: begin
					// loads the divider first, then one quotient bit per cycle
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						state_q <= S_RD;
					end
				end
				S_RD:   state_q <= S_WR;
				S_WR:   state_q <= sts.kind ? S_OUT : S_IDLE;
				S_OUT: begin
					if (cmd.out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== hdl/hemicube_form_factor_accumulator_core.sv =====
// An accumulate beat reaches the table after the row split, five arithmetic
// stages and the divider, then read and write; a read beat passes read and
// write before out_valid, and an id outside the table goes straight to output.
// One beat in flight: the next beat is taken only once the core is back in idle,
// which after a read also waits out any output stall.
// After reset (asynchronous, active low) the table is swept to zero before a beat is taken.
`default_nettype none
module hemicube_form_factor_accumulator_core #(
	parameter int unsigned RES = 128,
	parameter int unsigned MAX_PATCHES = 1024
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        kind,
	input  wire logic [2:0]  face,
	input  wire logic [13:0] pixel_index,
	input  wire logic [23:0] visible_id,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [33:0]      ff_accum,
	output logic             present
);
	import hffa_pkg::*;

	localparam int unsigned AW = $clog2(MAX_PATCHES);

	hffa_cmd_t     cmd;
	hffa_sts_t     sts;
	logic [AW-1:0] clr_addr;

	hffa_ctrl #(.MAX_PATCHES(MAX_PATCHES), .AW(AW)) u_ctrl (
		.clk, .arst_n, .in_valid, .in_stall, .out_valid, .out_stall,
		.sts, .cmd, .clr_addr
	);

	hffa_datapath #(.RES(RES), .MAX_PATCHES(MAX_PATCHES), .AW(AW)) u_dp (
		.clk, .cmd, .clr_addr, .kind, .face, .pixel_index, .visible_id,
		.sts, .ff_accum, .present
	);
endmodule
`default_nettype wire

// ===== hdl/hffa_checker.sv =====
`default_nettype none
module hffa_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_stall,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [33:0] ff_accum,
	input wire logic        present
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(ff_accum) && $stable(present))
		else $error("stalled result changed");

	a_absent_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !present |-> ff_accum == 34'd0)
		else $error("untouched entry has nonzero sum");

	a_one_beat: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second beat accepted while busy");
endmodule

bind hemicube_form_factor_accumulator_core hffa_checker u_chk (
	.clk, .arst_n, .in_valid, .in_stall, .out_valid, .out_stall, .ff_accum, .present
);
`default_nettype wire

// ===== dv/hemicube_form_factor_accumulator_core_test.sv =====
`default_nettype none
module hemicube_form_factor_accumulator_core_test;
	timeunit 1ns;
	timeprecision 1ps;
	import hffa_pkg::*;

	localparam int unsigned RES = 128;
	localparam int unsigned MAX_PATCHES = 1024;
	localparam logic KIND_ACC = 1'b0;
	localparam logic KIND_READ = 1'b1;
	localparam logic [63:0] INV_PI = 64'd1367130551;

	typedef struct packed {
		logic [33:0] ff_accum;
		logic        present;
	} ff_result_t;

	class ff_scoreboard;
		logic [33:0] sum_tbl [MAX_PATCHES];
		logic        hit_tbl [MAX_PATCHES];
		ff_result_t  pending [$];
		int          errors;

		function new();
			for (int i = 0; i < MAX_PATCHES; i++) begin
				sum_tbl[i] = '0;
				hit_tbl[i] = 1'b0;
			end
			errors = 0;
		endfunction

		function logic [63:0] weight(logic [2:0] f, logic [13:0] idx);
			longint col, row, u, v;
			logic [63:0] d, k;
			col = idx % RES;
			row = idx / RES;
			u = 2 * col + 1 - RES;
			v = 2 * row + 1 - RES;
			d = u * u + v * v + RES * RES;
			if (f == 3'd0)
				k = 4 * RES * RES;
			else begin
				if (v < 0)
					return 0;
				k = 4 * RES * v;
			end
			return (k * INV_PI) / (d * d);
		endfunction

		function void note_input(logic kd, logic [2:0] f, logic [13:0] idx, logic [23:0] id);
			ff_result_t r;
			logic [63:0] w, s;
			if (kd == KIND_READ) begin
				if (id < MAX_PATCHES) begin
					r.ff_accum = sum_tbl[id];
					r.present = hit_tbl[id];
					sum_tbl[id] = '0;
					hit_tbl[id] = 1'b0;
				end else
					r = '0;
				pending = {pending, r};
				return;
			end
			if (id == BACKGROUND_ID || id >= MAX_PATCHES || f > 3'd4 || idx >= RES * RES)
				return;
			if (f != 3'd0 && idx < (RES * RES) / 2)
				return;
			w = weight(f, idx);
			s = {30'd0, sum_tbl[id]} + w;
			if (w > SUM_MAX || s > SUM_MAX)
				s = SUM_MAX;
			sum_tbl[id] = s[33:0];
			hit_tbl[id] = 1'b1;
		endfunction

		function void check_result(logic [33:0] ff, logic pr);
			ff_result_t e;
			if (pending.size() == 0) begin
				$error("unexpected result ff_accum=%0d present=%0d", ff, pr);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (ff !== e.ff_accum) begin
				$error("ff_accum expected %0d actual %0d", e.ff_accum, ff);
				errors++;
			end
			if (pr !== e.present) begin
				$error("present expected %0d actual %0d", e.present, pr);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic        kind;
	logic [2:0]  face;
	logic [13:0] pixel_index;
	logic [23:0] visible_id;
	logic        out_valid;
	logic        out_stall;
	logic [33:0] ff_accum;
	logic        present;
	logic        calm;

	ff_scoreboard ffs;

	hemicube_form_factor_accumulator_core #(.RES(RES), .MAX_PATCHES(MAX_PATCHES)) i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.kind(kind), .face(face), .pixel_index(pixel_index), .visible_id(visible_id),
		.out_valid(out_valid), .out_stall(out_stall),
		.ff_accum(ff_accum), .present(present)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("FAIL hemicube_form_factor_accumulator_core");
		$finish;
	end

	// Drive one beat, holding it until accepted; gaps only before the beat,
	// so valid stays high into the next beat when no gap is drawn.
	task automatic send_beat(logic kd, logic [2:0] f, logic [13:0] idx, logic [23:0] id);
		while (!calm && $urandom_range(99) < 32) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= kd;
		face <= f;
		pixel_index <= idx;
		visible_id <= id;
		do
			@(posedge clk);
		while (in_stall);
		ffs.note_input(kd, f, idx, id);
	endtask

	task automatic send_random();
		logic [23:0] id;
		logic [13:0] idx;
		logic [2:0]  f;
		int p;
		p = $urandom_range(99);
		if (p < 70)
			id = 24'($urandom_range(15));
		else if (p < 85)
			id = 24'($urandom_range(MAX_PATCHES - 1));
		else if (p < 92)
			id = BACKGROUND_ID;
		else
			id = 24'($urandom);
		if ($urandom_range(99) < 80)
			f = 3'($urandom_range(4));
		else
			f = 3'($urandom);
		idx = ($urandom_range(99) < 90) ? 14'($urandom_range(RES * RES - 1)) : 14'($urandom);
		if ($urandom_range(99) < 20)
			send_beat(KIND_READ, 3'($urandom), 14'($urandom),
				($urandom_range(9) < 8) ? 24'($urandom_range(15)) : 24'($urandom));
		else
			send_beat(KIND_ACC, f, idx, id);
	endtask

	// Sample results on the edge; stall drawn fresh each cycle.
	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall)
				ffs.check_result(ff_accum, present);
			out_stall <= (!calm && $urandom_range(99) < 32);
		end
	end

	initial begin
		int wait_cnt;
		ffs = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		kind = 1'b0;
		face = '0;
		pixel_index = '0;
		visible_id = '0;
		calm = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reads after reset, extremes and the id, face and side-half skip rules
		send_beat(KIND_READ, 3'd0, 14'd0, 24'd0);
		send_beat(KIND_READ, 3'd7, 14'h3FFF, 24'd1023);
		send_beat(KIND_READ, 3'd0, 14'd0, 24'd1024);
		send_beat(KIND_READ, 3'd0, 14'd0, BACKGROUND_ID);
		send_beat(KIND_ACC, 3'd0, 14'd0, 24'd1);
		send_beat(KIND_ACC, 3'd0, 14'd8256, 24'd1);
		send_beat(KIND_ACC, 3'd0, 14'd16383, 24'd1023);
		send_beat(KIND_ACC, 3'd1, 14'd8191, 24'd2);
		send_beat(KIND_ACC, 3'd2, 14'd8192, 24'd2);
		send_beat(KIND_ACC, 3'd3, 14'd16383, 24'd2);
		send_beat(KIND_ACC, 3'd4, 14'd12000, 24'd2);
		send_beat(KIND_ACC, 3'd5, 14'd100, 24'd3);
		send_beat(KIND_ACC, 3'd7, 14'd100, 24'd3);
		send_beat(KIND_ACC, 3'd0, 14'd100, BACKGROUND_ID);
		send_beat(KIND_ACC, 3'd0, 14'd100, 24'd1024);
		send_beat(KIND_ACC, 3'd0, 14'h3FFF, 24'hAAAAAA);
		for (int i = 0; i < 6; i++)
			send_beat(KIND_READ, 3'd0, 14'd0, 24'(i));
		send_beat(KIND_READ, 3'd0, 14'd0, 24'd1023);

		for (int i = 0; i < 1700; i++) begin
			calm = (i >= 700 && i < 900);
			send_random();
		end
		calm = 1'b0;
		for (int i = 0; i < 16; i++)
			send_beat(KIND_READ, 3'd0, 14'd0, 24'(i));
		in_valid <= 1'b0;

		wait_cnt = 0;
		while (ffs.pending.size() != 0 && wait_cnt < 100000) begin
			@(posedge clk);
			wait_cnt++;
		end
		repeat (100) @(posedge clk);
		if (ffs.errors == 0 && ffs.pending.size() == 0)
			$display("PASS hemicube_form_factor_accumulator_core");
		else
			$display("FAIL hemicube_form_factor_accumulator_core");
		$finish;
	end
endmodule
`default_nettype wire

// ===== files.f =====
hdl/hffa_pkg.sv
hdl/hffa_datapath.sv
hdl/hffa_ctrl.sv
hdl/hemicube_form_factor_accumulator_core.sv
hdl/hffa_checker.sv
dv/hemicube_form_factor_accumulator_core_test.sv
